// ===== hdl/mbf_pkg.sv =====
// Shared types, constants and helper functions for the Modbus RTU
// write-multiple-registers framer. No dependencies.
`default_nettype none

package mbf_pkg;

  localparam int MAX_PAYLOAD_BYTES = 246;

  localparam logic [7:0]  FUNC_CODE      = 8'h10;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] CRC_SHIFT_MASK = 16'h7FFF;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_ADDR  = 2'd0,
    CFG_START_REG   = 2'd1,
    CFG_PAYLOAD_LEN = 2'd2
  } cfg_index_t;

  // Configuration as seen by the back end; length already clamped
  typedef struct packed {
    logic [7:0]  slave_address;
    logic [15:0] start_register;
    logic [7:0]  length;
  } cfg_t;

  // One classified payload byte
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } item_t;

  // Clamp the programmed length into 1 .. MAX_PAYLOAD_BYTES
  function automatic logic [7:0] clamp_length(input logic [7:0] len);
    logic [7:0] res;
    res = len;
    if (len == 8'd0) begin
      res = 8'd1;
    end else if (len > 8'(MAX_PAYLOAD_BYTES)) begin
      res = 8'(MAX_PAYLOAD_BYTES);
    end
    return res;
  endfunction

  // One byte of reflected CRC-16, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    logic        lsb;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      lsb = c[0];
      c   = (c >> 1) & CRC_SHIFT_MASK;
      if (lsb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mbf_queue.sv =====
// Two-entry queue of classified payload bytes between front and back.
// Depends on mbf_pkg.
`default_nettype none

module mbf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mbf_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output mbf_pkg::item_t      head_item
);

  mbf_pkg::item_t                 mem_r [mbf_pkg::Q_DEPTH];
  logic [mbf_pkg::Q_PTR_W-1:0]    wr_ptr_r;
  logic [mbf_pkg::Q_PTR_W-1:0]    rd_ptr_r;
  logic [mbf_pkg::Q_CNT_W-1:0]    count_r;
  logic [mbf_pkg::Q_CNT_W-1:0]    count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (count_r == mbf_pkg::Q_CNT_W'(mbf_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        mem_r[wr_ptr_r] <= push_item;
        wr_ptr_r <= (wr_ptr_r == mbf_pkg::Q_PTR_W'(mbf_pkg::Q_DEPTH - 1)) ? '0
                                                                          : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == mbf_pkg::Q_PTR_W'(mbf_pkg::Q_DEPTH - 1)) ? '0
                                                                          : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mbf_front.sv =====
// Front end: configuration registers, input beat acceptance and
// classification of each payload byte as first/last of a frame. Depends on mbf_pkg.
`default_nettype none

module mbf_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mbf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mbf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output mbf_pkg::item_t                       q_item,
  output mbf_pkg::cfg_t                        cfg
);

  logic [7:0]  slave_addr_r;
  logic [15:0] start_reg_r;
  logic [7:0]  length_r;
  logic [7:0]  count_r;
  logic [7:0]  count_nxt;
  logic [7:0]  len_eff;
  logic        is_last;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign len_eff   = mbf_pkg::clamp_length(length_r);

  // Frame ends once the taken count reaches the clamped length
  assign is_last   = ({1'b0, count_r} + 9'd1) >= {1'b0, len_eff};
  assign count_nxt = is_last ? 8'd0 : count_r + 8'd1;

  assign q_push        = accept;
  assign q_item.data   = in_tdata;
  assign q_item.first  = (count_r == 8'd0);
  assign q_item.last   = is_last;

  assign cfg.slave_address  = slave_addr_r;
  assign cfg.start_register = start_reg_r;
  assign cfg.length         = len_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd1;
      start_reg_r  <= 16'd1;
      length_r     <= 8'd246;
      count_r      <= 8'd0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          mbf_pkg::CFG_SLAVE_ADDR:  slave_addr_r <= cfg_data[7:0];
          mbf_pkg::CFG_START_REG:   start_reg_r  <= cfg_data;
          mbf_pkg::CFG_PAYLOAD_LEN: length_r     <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mbf_back.sv =====
// Back end: byte sequencer that expands each queued payload byte into
// header, data and CRC bytes, with the running CRC and output register. Depends on mbf_pkg.
`default_nettype none

module mbf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mbf_pkg::cfg_t  cfg,
  input  wire logic           head_valid,
  input  wire mbf_pkg::item_t head_item,
  output logic                q_pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  output logic                out_tuser
);

  typedef enum logic [3:0] {
    PH_ADDR   = 4'd0,
    PH_FUNC   = 4'd1,
    PH_REG_HI = 4'd2,
    PH_REG_LO = 4'd3,
    PH_CNT_HI = 4'd4,
    PH_CNT_LO = 4'd5,
    PH_BYTES  = 4'd6,
    PH_DATA   = 4'd7,
    PH_CRC_LO = 4'd8,
    PH_CRC_HI = 4'd9
  } phase_t;

  phase_t      phase_r;
  phase_t      eff;
  logic [15:0] crc_r;
  logic [15:0] crc_in;
  logic [15:0] crc_upd;
  logic [7:0]  byte_sel;
  logic [7:0]  words;
  logic        emit;
  logic        entry_done;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        frame_last_r;
  logic        run_last_r;

  // Only a first byte of a frame starts with the header
  assign eff   = (phase_r == PH_ADDR && !head_item.first) ? PH_DATA : phase_r;
  assign emit  = head_valid && (!out_valid_r || out_tready);
  assign words = {1'b0, cfg.length[7:1]};

  always_comb begin
    unique case (eff)
      PH_ADDR:   byte_sel = cfg.slave_address;
      PH_FUNC:   byte_sel = mbf_pkg::FUNC_CODE;
      PH_REG_HI: byte_sel = cfg.start_register[15:8];
      PH_REG_LO: byte_sel = cfg.start_register[7:0];
      PH_CNT_HI: byte_sel = 8'h00;
      PH_CNT_LO: byte_sel = words;
      PH_BYTES:  byte_sel = cfg.length;
      PH_DATA:   byte_sel = head_item.data;
      PH_CRC_LO: byte_sel = crc_r[7:0];
      PH_CRC_HI: byte_sel = crc_r[15:8];
      default:   byte_sel = 8'h00;
    endcase
  end

  assign crc_in     = (eff == PH_ADDR) ? mbf_pkg::CRC_INIT : crc_r;
  assign crc_upd    = mbf_pkg::crc_byte(crc_in, byte_sel);
  assign entry_done = (eff == PH_DATA && !head_item.last) || (eff == PH_CRC_HI);
  assign q_pop      = emit && entry_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ADDR;
      crc_r       <= mbf_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r  <= 1'b1;
        out_byte_r   <= byte_sel;
        run_last_r   <= entry_done;
        frame_last_r <= (eff == PH_CRC_HI);
        if (eff != PH_CRC_LO && eff != PH_CRC_HI) begin
          crc_r <= crc_upd;
        end
        phase_r <= entry_done ? PH_ADDR : phase_t'(eff + 4'd1);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = frame_last_r;
  assign out_tuser  = run_last_r;

endmodule

`default_nettype wire

// ===== hdl/modbus_rtu_write_multiple_framer.sv =====
// Top level of the Modbus RTU write-multiple-registers request framer.
// Depends on mbf_pkg, mbf_front, mbf_queue and mbf_back.
//
// Takes a stream of payload bytes and produces a complete function 0x10
// request: the first payload byte of a frame is preceded by the header
// (slave address, 0x10, start register high/low, word count high/low,
// byte count), every payload byte is passed through, and the last one is
// followed by the CRC-16 (init 0xFFFF, reflected polynomial 0xA001), low
// byte first. The output runs at one frame byte per clock whenever the
// sink is ready and a payload byte is queued: a middle payload byte
// yields only itself, the first byte of a frame also the header before
// it, the last also the two CRC bytes after it. The CRC update for each
// byte completes within the same cycle. A two-beat queue sits between
// the input side and the sequencer, so besides the beat being expanded
// one further input beat is still taken while header or CRC bytes drain
// or the sink stalls; after that the input waits. out_tuser marks the last
// byte caused by one input beat, out_tlast the final CRC byte of a frame.
// A payload length of 0 is used as 1 and one above 246 as 246, and the
// header carries the length so used. Write configuration only while the
// block is idle; cfg_ready is always high and writes to index 3 are
// dropped. There is no clearing pass after reset.
`default_nettype none

module modbus_rtu_write_multiple_framer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mbf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mbf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // payload beats in
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] data_byte
  // frame beats out
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [7:0]                           out_tdata,  // [7:0] frame_byte
  output logic                                 out_tlast,  // frame_last
  output logic                                 out_tuser   // [0] run_last
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           head_valid;
  mbf_pkg::item_t q_item;
  mbf_pkg::item_t head_item;
  mbf_pkg::cfg_t  cfg;

  // Front: hold configuration, count payload beats, classify each one
  mbf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item),
    .cfg       (cfg)
  );

  // Decouple: buffer classified beats so either side may stall alone
  mbf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Back: expand each beat into header, data and CRC bytes
  mbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== hdl/mbf_checker.sv =====
// Port-level checks for the framer top level, bound to it below.
// Depends on modbus_rtu_write_multiple_framer.
`default_nettype none

module mbf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic       out_tuser
);

  // The end of a frame is always the end of an input beat's run
  a_frame_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("frame end without run end");

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                  && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output beat changed");

  // Reset empties the output and the queue
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output or queue not cleared by reset");

  // Two CRC bytes cannot both end a frame back to back
  a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !(out_tvalid && out_tlast))
    else $error("two frame ends in a row");

endmodule

bind modbus_rtu_write_multiple_framer mbf_checker u_mbf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
